// File: rtl/qdpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_pkg
// Shared widths, register indexes, state and command types for the
// quantised dot product and requantise block.
// ----------------------------------------------------------------------------
package qdpr_pkg;

  // payload widths
  localparam int ByteW   = 8;
  localparam int AccW    = 32;
  localparam int MultW   = 31;
  localparam int ShiftW  = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_ZP  = 3'd0,
    REG_WGT_ZP = 3'd1,
    REG_OUT_ZP = 3'd2,
    REG_MULT   = 3'd3,
    REG_SHIFT  = 3'd4
  } cfg_reg_t;

  // reset value of the multiplier, 0.5 in Q31
  localparam logic [MultW-1:0] MultReset = 31'h4000_0000;

  // controller states
  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_HIGH,
    ST_SHR,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic high_en;
    logic shr_en;
    logic emit_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage : qdpr_pkg
`default_nettype wire

// File: rtl/qdpr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_in_if
// Operand stream: activation, weight, bias and last flag.
// ----------------------------------------------------------------------------
interface qdpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [qdpr_pkg::ByteW-1:0]          in_value;
  logic [qdpr_pkg::ByteW-1:0]          weight_value;
  logic signed [qdpr_pkg::AccW-1:0]    bias_value;
  logic                                last;

  modport source (output valid, in_value, weight_value, bias_value, last, input ready);
  modport sink   (input valid, in_value, weight_value, bias_value, last, output ready);
endinterface : qdpr_in_if
`default_nettype wire

// File: rtl/qdpr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_out_if
// Result stream: one requantised byte per dot product.
// ----------------------------------------------------------------------------
interface qdpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [qdpr_pkg::ByteW-1:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface : qdpr_out_if
`default_nettype wire

// File: rtl/qdpr_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface qdpr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qdpr_pkg::CfgIdxW-1:0] index;
  logic [qdpr_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : qdpr_cfg_if
`default_nettype wire

// File: rtl/qdpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_ctrl
// Sequencer: accumulates operand transfers, then steps the datapath
// through multiply, high half, rounding shift and emit.
// ----------------------------------------------------------------------------
module qdpr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  output logic                in_ready,
  input  wire qdpr_pkg::sts_t sts,
  output qdpr_pkg::cmd_t      cmd
);

  qdpr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qdpr_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qdpr_pkg::ST_ACC: begin
        if (in_valid && in_last) state_nxt = qdpr_pkg::ST_MUL;
      end
      qdpr_pkg::ST_MUL:  state_nxt = qdpr_pkg::ST_HIGH;
      qdpr_pkg::ST_HIGH: state_nxt = qdpr_pkg::ST_SHR;
      qdpr_pkg::ST_SHR:  state_nxt = qdpr_pkg::ST_EMIT;
      qdpr_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = qdpr_pkg::ST_ACC;
      end
      default: state_nxt = qdpr_pkg::ST_ACC;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state_r == qdpr_pkg::ST_ACC);
    cmd.acc_en  = in_valid && (state_r == qdpr_pkg::ST_ACC);
    cmd.mul_en  = (state_r == qdpr_pkg::ST_MUL);
    cmd.high_en = (state_r == qdpr_pkg::ST_HIGH);
    cmd.shr_en  = (state_r == qdpr_pkg::ST_SHR);
    cmd.emit_en = (state_r == qdpr_pkg::ST_EMIT) && sts.out_free;
  end

endmodule : qdpr_ctrl
`default_nettype wire

// File: rtl/qdpr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_dp
// Datapath: configuration registers, multiply-accumulate, requantise
// stages and the output register.
// ----------------------------------------------------------------------------
module qdpr_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [qdpr_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [qdpr_pkg::CfgDatW-1:0]        cfg_data,
  input  wire logic [qdpr_pkg::ByteW-1:0]          in_value,
  input  wire logic [qdpr_pkg::ByteW-1:0]          weight_value,
  input  wire logic signed [qdpr_pkg::AccW-1:0]    bias_value,
  input  wire logic                                in_last,
  input  wire qdpr_pkg::cmd_t                      cmd,
  output qdpr_pkg::sts_t                           sts,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [qdpr_pkg::ByteW-1:0]               out_value
);

  localparam int AccW  = qdpr_pkg::AccW;
  localparam int ByteW = qdpr_pkg::ByteW;
  localparam int HiW   = AccW + 1;

  // configuration
  logic [ByteW-1:0]              izp_r, wzp_r, ozp_r;
  logic [qdpr_pkg::MultW-1:0]    mult_r;
  logic [qdpr_pkg::ShiftW-1:0]   shift_r;

  // working registers
  logic [AccW-1:0]               acc_r, acc_nxt;
  logic [AccW-1:0]               fin_r;
  logic [qdpr_pkg::ShiftW-1:0]   right_r;
  logic signed [2*AccW-1:0]      prod_r;
  logic signed [HiW-1:0]         high_r;
  logic signed [HiW-1:0]         shr_r;
  logic                          out_valid_r;
  logic [ByteW-1:0]              out_value_r, out_value_nxt;

  // combinational terms
  logic signed [ByteW:0]         act_d, wgt_d;
  logic signed [2*ByteW+1:0]     mac_prod;
  logic [AccW-1:0]               mac_sum;
  logic [4:0]                    left_amt;
  logic [qdpr_pkg::ShiftW-1:0]   right_amt;
  logic [AccW-1:0]               shifted;
  logic signed [2*AccW-1:0]      mul_full;
  logic signed [2*AccW-1:0]      nudge, nudged;
  logic                          trunc_fix;
  logic [HiW-1:0]                rmask, rrem, rthr;
  logic                          round_up;
  logic signed [HiW:0]           with_zp;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      izp_r   <= '0;
      wzp_r   <= '0;
      ozp_r   <= '0;
      mult_r  <= qdpr_pkg::MultReset;
      shift_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qdpr_pkg::REG_IN_ZP:  izp_r   <= cfg_data[ByteW-1:0];
        qdpr_pkg::REG_WGT_ZP: wzp_r   <= cfg_data[ByteW-1:0];
        qdpr_pkg::REG_OUT_ZP: ozp_r   <= cfg_data[ByteW-1:0];
        qdpr_pkg::REG_MULT:   mult_r  <= cfg_data[qdpr_pkg::MultW-1:0];
        qdpr_pkg::REG_SHIFT:  shift_r <= cfg_data[qdpr_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // multiply-accumulate of one operand pair, bias added on the last
  always_comb begin
    act_d    = $signed({1'b0, in_value}) - $signed({1'b0, izp_r});
    wgt_d    = $signed({1'b0, weight_value}) - $signed({1'b0, wzp_r});
    mac_prod = act_d * wgt_d;
    mac_sum  = acc_r + {{(AccW - 2*ByteW - 2){mac_prod[2*ByteW+1]}}, mac_prod};
    acc_nxt  = in_last ? '0 : mac_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && in_last) begin
      fin_r <= mac_sum + bias_value;
    end
  end

  // optional left shift, then the q31 multiply
  always_comb begin
    left_amt  = shift_r[qdpr_pkg::ShiftW-1] ? '0 : shift_r[4:0];
    right_amt = shift_r[qdpr_pkg::ShiftW-1] ? qdpr_pkg::ShiftW'(-$signed(shift_r)) : '0;
    shifted   = fin_r << left_amt;
    mul_full  = $signed(shifted) * $signed({1'b0, mult_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r  <= mul_full;
      right_r <= right_amt;
    end
  end

  // rounding doubling high half: divide by 2^31 towards zero after nudge
  always_comb begin
    nudge     = prod_r[2*AccW-1] ? (64'sd1 - 64'sd1073741824) : 64'sd1073741824;
    nudged    = prod_r + nudge;
    trunc_fix = nudged[2*AccW-1] && (|nudged[AccW-2:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.high_en) begin
      high_r <= $signed(nudged[2*AccW-1:AccW-1]) + $signed({{(HiW-1){1'b0}}, trunc_fix});
    end
  end

  // rounding right shift, ties away from zero
  always_comb begin
    rmask    = ({{(HiW-1){1'b0}}, 1'b1} << right_r) - {{(HiW-1){1'b0}}, 1'b1};
    rrem     = high_r & rmask;
    rthr     = (rmask >> 1) + {{(HiW-1){1'b0}}, high_r[HiW-1]};
    round_up = (rrem > rthr);
  end

  always_ff @(posedge clk) begin
    if (cmd.shr_en) begin
      shr_r <= (high_r >>> right_r) + $signed({{(HiW-1){1'b0}}, round_up});
    end
  end

  // add output zero point and clamp to a byte
  always_comb begin
    with_zp = $signed({shr_r[HiW-1], shr_r}) + $signed({{(HiW+1-ByteW){1'b0}}, ozp_r});
    if (with_zp[HiW]) begin
      out_value_nxt = '0;
    end else if (|with_zp[HiW-1:ByteW]) begin
      out_value_nxt = '1;
    end else begin
      out_value_nxt = with_zp[ByteW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;

endmodule : qdpr_dp
`default_nettype wire

// File: rtl/quantized_dot_product_requantize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_dot_product_requantize
// One output of a uint8 quantised fully connected layer: multiply-accumulate
// of operand pairs, bias, fixed-point requantise, zero point and clamp.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  in_ch    in   in_value, weight_value, bias_value, last       valid/ready
//  out_ch   out  out_value                                      valid/ready
//  cfg_ch   in   index (3 bit), data (32 bit)                   valid/ready
//
//  A non-last transfer is added to the accumulator; one transfer per cycle
//  while no requantise runs. A last transfer steps through accumulate,
//  multiply, high half, rounding shift, emit, around the single 32x32 multiply.
//  The result sits in an output register; a stalled sink holds only the emit.
//  Reset is synchronous active low: state, accumulator, config, output valid.
//  Register writes are always ready.
// ----------------------------------------------------------------------------
module quantized_dot_product_requantize (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qdpr_in_if.sink    in_ch,
  qdpr_out_if.source out_ch,
  qdpr_cfg_if.sink   cfg_ch
);

  qdpr_pkg::cmd_t cmd;
  qdpr_pkg::sts_t sts;
  logic           cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  // sequencer
  qdpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic
  qdpr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .in_value     (in_ch.in_value),
    .weight_value (in_ch.weight_value),
    .bias_value   (in_ch.bias_value),
    .in_last      (in_ch.last),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_value    (out_ch.out_value)
  );

endmodule : quantized_dot_product_requantize
`default_nettype wire

// File: rtl/qdpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_checker
// Port level checks on the result stream and the requantise sequence.
// ----------------------------------------------------------------------------
module qdpr_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_last,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [qdpr_pkg::ByteW-1:0] out_value
);

  // a pending result stays until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result changed while stalled");

  // a last transfer blocks the input through multiply, high half, shift and emit
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last
      |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken during requantise");

  // a new result only comes out of the emit step, when input is blocked
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared outside the requantise sequence");

endmodule : qdpr_checker

bind quantized_dot_product_requantize qdpr_checker u_qdpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value)
);
`default_nettype wire
